/* rtl/core/xex_pkg.sv */
// Shared types, constants and AES helper functions for the XEX cipher layer.
// No dependencies; used by xex_ctrl, xex_dp and the top level.
package xex_pkg;

  localparam int unsigned BLK_W = 128;
  localparam int unsigned HALF_W = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned RND_W = 4;
  localparam logic [RND_W-1:0] LAST_RND = 4'd10;
  localparam logic [RND_W-1:0] RND_SUM = 4'd11;
  localparam logic [7:0] GF_POLY = 8'h87;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd4;

  typedef struct packed {
    logic load_key;
    logic key_step;
    logic save_last;
    logic start;
    logic round_step;
    logic finish;
    logic fin_direct;
    logic [RND_W-1:0] rnd;
  } xex_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] rcon(input logic [RND_W-1:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // SubWord(RotWord(w)) ^ rcon, the nonlinear part of one key schedule step
  function automatic logic [31:0] key_mix(input logic [31:0] w, input logic [RND_W-1:0] r);
    logic [31:0] rw;
    rw = {w[23:0], w[31:24]};
    return {SBOX[rw[31:24]] ^ rcon(r), SBOX[rw[23:16]], SBOX[rw[15:8]], SBOX[rw[7:0]]};
  endfunction

  // round key r from round key r-1
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [RND_W-1:0] r);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[127:96] ^ key_mix(k[31:0], r);
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // round key r-1 from round key r
  function automatic logic [127:0] key_prev(input logic [127:0] k, input logic [RND_W-1:0] r);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    p0 = k[127:96] ^ key_mix(p3, r);
    return {p0, p1, p2, p3};
  endfunction

  function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (!last) begin
        t[4*c] = a0 ^ all ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    return o ^ k;
  endfunction

  function automatic logic [127:0] inv_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [127:0] u;
    logic [127:0] o;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        u[127-8*(4*c+r) -: 8] = INV_SBOX[s[127-8*(4*((c+4-r)%4)+r) -: 8]];
      end
    end
    u = u ^ k;
    o = u;
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          a[r] = u[127-8*(4*c+r) -: 8];
          x2[r] = xtime(a[r]);
          x4[r] = xtime(x2[r]);
          x8[r] = xtime(x4[r]);
        end
        // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1
        for (int r = 0; r < 4; r++) begin
          o[127-8*(4*c+r) -: 8] = (x8[r] ^ x4[r] ^ x2[r])
            ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
            ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
            ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
        end
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] m);
    return {m[126:0], 1'b0} ^ {120'd0, (m[127] ? GF_POLY : 8'h00)};
  endfunction

endpackage

/* rtl/core/xex_ctrl.sv */
// Sequencer for the XEX cipher layer: key expansion sweep, rounds, result handoff.
// Depends on xex_pkg.
module xex_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                key_wr,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output xex_pkg::xex_cmd_t   cmd
);

  typedef enum logic [2:0] {S_KLOAD, S_KEXP, S_IDLE, S_ROUND, S_HOLD} state_t;

  state_t state_r;
  logic [xex_pkg::RND_W-1:0] cnt_r;
  logic out_valid_r;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.rnd = cnt_r;
    unique case (state_r)
      S_KLOAD: cmd.load_key = 1'b1;
      S_KEXP: begin
        cmd.key_step = 1'b1;
        cmd.save_last = (cnt_r == xex_pkg::LAST_RND);
      end
      S_IDLE: cmd.start = in_valid;
      S_ROUND: begin
        cmd.round_step = 1'b1;
        cmd.finish = (cnt_r == xex_pkg::LAST_RND) && out_free;
        cmd.fin_direct = 1'b1;
      end
      S_HOLD: cmd.finish = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_KLOAD;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish || (out_valid_r && out_stall);
      if (key_wr) begin
        // restart the sweep on every key half written
        state_r <= S_KLOAD;
      end else begin
        unique case (state_r)
          S_KLOAD: begin
            cnt_r <= 4'd1;
            state_r <= S_KEXP;
          end
          S_KEXP: begin
            cnt_r <= cnt_r + 4'd1;
            if (cnt_r == xex_pkg::LAST_RND) state_r <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid) begin
              cnt_r <= 4'd1;
              state_r <= S_ROUND;
            end
          end
          S_ROUND: begin
            cnt_r <= cnt_r + 4'd1;
            if (cnt_r == xex_pkg::LAST_RND) state_r <= out_free ? S_IDLE : S_HOLD;
          end
          S_HOLD: if (out_free) state_r <= S_IDLE;
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

endmodule

/* rtl/core/xex_dp.sv */
// Datapath for the XEX cipher layer: config registers, mask, round key, AES state.
// Depends on xex_pkg; driven by xex_ctrl commands.
module xex_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [xex_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [xex_pkg::HALF_W-1:0]          cfg_wdata,
  input  logic [xex_pkg::HALF_W-1:0]          in_block_high,
  input  logic [xex_pkg::HALF_W-1:0]          in_block_low,
  input  logic                                in_message_start,
  input  xex_pkg::xex_cmd_t                   cmd,
  output logic [xex_pkg::HALF_W-1:0]          out_result_high,
  output logic [xex_pkg::HALF_W-1:0]          out_result_low
);

  logic [xex_pkg::BLK_W-1:0] key_r, base_r, mask_r, mask_nxt, rkey_r, last_r;
  logic [xex_pkg::BLK_W-1:0] state_r, res_r, key0, rkey_nxt, round_out, fwd_key;
  logic dec_r, last_rnd;

  assign last_rnd = (cmd.rnd == xex_pkg::LAST_RND);
  assign fwd_key = xex_pkg::key_next(rkey_r, cmd.rnd);
  assign rkey_nxt = dec_r ? xex_pkg::key_prev(rkey_r, 4'(xex_pkg::RND_SUM - cmd.rnd)) : fwd_key;
  assign round_out = dec_r ? xex_pkg::inv_round(state_r, rkey_nxt, last_rnd)
                           : xex_pkg::fwd_round(state_r, rkey_nxt, last_rnd);
  assign mask_nxt = xex_pkg::gf_double(in_message_start ? base_r : mask_r);
  assign key0 = dec_r ? last_r : key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      base_r <= '0;
      dec_r <= 1'b0;
      mask_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          xex_pkg::CFG_KEY_HIGH: key_r[127:64] <= cfg_wdata;
          xex_pkg::CFG_KEY_LOW: key_r[63:0] <= cfg_wdata;
          xex_pkg::CFG_BASE_HIGH: base_r[127:64] <= cfg_wdata;
          xex_pkg::CFG_BASE_LOW: base_r[63:0] <= cfg_wdata;
          xex_pkg::CFG_MODE: dec_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.start) mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) rkey_r <= key_r;
    else if (cmd.key_step) rkey_r <= fwd_key;
    else if (cmd.start) rkey_r <= key0;
    else if (cmd.round_step) rkey_r <= rkey_nxt;
    if (cmd.save_last) last_r <= fwd_key;
    if (cmd.start) state_r <= {in_block_high, in_block_low} ^ mask_nxt ^ key0;
    else if (cmd.round_step) state_r <= round_out;
    if (cmd.finish) res_r <= (cmd.fin_direct ? round_out : state_r) ^ mask_r;
  end

  assign out_result_high = res_r[127:64];
  assign out_result_low = res_r[63:0];

endmodule

/* rtl/core/xex_block_cipher_layer_unit.sv */
// XEX layer over AES-128 with a GF(2^128) doubling mask; one result per block.
// An input transfer loads the masked, whitened block; ten rounds then run on the single
// shared AES round unit, and no new block is taken until the result is registered.
// Reset and every key write run a key expansion sweep to find the last
// round key; no input is taken during it. Reset clears key, mask and mode to zero.
// Depends on xex_pkg, xex_ctrl and xex_dp.
module xex_block_cipher_layer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [xex_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [xex_pkg::HALF_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [xex_pkg::HALF_W-1:0]          in_block_high,
  input  logic [xex_pkg::HALF_W-1:0]          in_block_low,
  input  logic                                in_message_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [xex_pkg::HALF_W-1:0]          out_result_high,
  output logic [xex_pkg::HALF_W-1:0]          out_result_low
);

  xex_pkg::xex_cmd_t cmd;
  logic key_wr;

  assign key_wr = cfg_we && ((cfg_index == xex_pkg::CFG_KEY_HIGH) ||
                             (cfg_index == xex_pkg::CFG_KEY_LOW));

  xex_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .key_wr    (key_wr),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  xex_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_block_high    (in_block_high),
    .in_block_low     (in_block_low),
    .in_message_start (in_message_start),
    .cmd              (cmd),
    .out_result_high  (out_result_high),
    .out_result_low   (out_result_low)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("input taken twice in a row");

  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid) else $error("finished result not presented");

  a_key_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr |=> in_stall) else $error("input open during key expansion");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_key, cmd.key_step, cmd.start, cmd.round_step}))
    else $error("conflicting datapath commands");

endmodule

/* dv/xex_checker.sv */
// Scoreboard for the XEX AES-128 layer: watches the config port and both channels,
// predicts each result and compares it with what the block returns. Uses xex_pkg.
module xex_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [xex_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xex_pkg::HALF_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [xex_pkg::HALF_W-1:0]    in_block_high,
  input  logic [xex_pkg::HALF_W-1:0]    in_block_low,
  input  logic                          in_message_start,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [xex_pkg::HALF_W-1:0]    out_result_high,
  input  logic [xex_pkg::HALF_W-1:0]    out_result_low,
  output int                            mismatch_count,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import xex_pkg::*;

  typedef struct packed {
    logic [HALF_W-1:0] high;
    logic [HALF_W-1:0] low;
  } block_t;

  logic [7:0]   fwd_sub [256];
  logic [7:0]   inv_sub [256];
  logic [127:0] round_key [11];
  logic [127:0] aes_key;
  logic [127:0] base_mask;
  logic [127:0] mask;
  logic         decrypt;
  block_t       expected_blocks [$];

  function automatic logic [7:0] mul2(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf8_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = mul2(a);
    end
    return acc;
  endfunction

  // Build the S-box from the field inverse walk plus the affine map.
  initial begin
    logic [7:0] p, q, x;
    p = 8'h01;
    q = 8'h01;
    do begin
      p = p ^ mul2(p);
      q = q ^ (q << 1);
      q = q ^ (q << 2);
      q = q ^ (q << 4);
      if (q[7]) q ^= 8'h09;
      x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]} ^ {q[3:0], q[7:4]};
      fwd_sub[p] = x ^ 8'h63;
    end while (p != 8'h01);
    fwd_sub[0] = 8'h63;
    for (int i = 0; i < 256; i++) inv_sub[fwd_sub[i]] = i[7:0];
  end

  function automatic void expand_schedule(input logic [127:0] k);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = k[127-32*i -: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_sub[t[31:24]] ^ rc, fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]};
        rc = mul2(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r <= 10; r++) round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, al;
    logic [127:0] v;
    v = blk ^ round_key[0];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int i = 0; i < 16; i++) s[i] = v[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[4*c+r] = fwd_sub[s[4*((c+r)%4)+r]];
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ mul2(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ mul2(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ mul2(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ mul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) v[127-8*i -: 8] = t[i];
      v ^= round_key[rnd];
    end
    return v;
  endfunction

  function automatic logic [127:0] aes_decrypt(input logic [127:0] blk);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [127:0] v;
    v = blk ^ round_key[10];
    for (int j = 1; j <= 10; j++) begin
      for (int i = 0; i < 16; i++) s[i] = v[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[4*c+r] = inv_sub[s[4*((c+4-r)%4)+r]];
      for (int i = 0; i < 16; i++) v[127-8*i -: 8] = t[i];
      v ^= round_key[10-j];
      if (j != 10) begin
        for (int i = 0; i < 16; i++) s[i] = v[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            t[4*c+r] = gf8_mul(s[4*c+r], 8'd14) ^ gf8_mul(s[4*c+(r+1)%4], 8'd11)
                     ^ gf8_mul(s[4*c+(r+2)%4], 8'd13) ^ gf8_mul(s[4*c+(r+3)%4], 8'd9);
        for (int i = 0; i < 16; i++) v[127-8*i -: 8] = t[i];
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    block_t got, want;
    logic [127:0] v;
    if (!rst_n) begin
      aes_key = '0;
      base_mask = '0;
      mask = '0;
      decrypt = 1'b0;
      expand_schedule(aes_key);
      expected_blocks.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_HIGH:  begin aes_key[127:64] = cfg_wdata; expand_schedule(aes_key); end
          CFG_KEY_LOW:   begin aes_key[63:0] = cfg_wdata; expand_schedule(aes_key); end
          CFG_BASE_HIGH: base_mask[127:64] = cfg_wdata;
          CFG_BASE_LOW:  base_mask[63:0] = cfg_wdata;
          CFG_MODE:      decrypt = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_message_start) mask = base_mask;
        mask = {mask[126:0], 1'b0} ^ (mask[127] ? 128'h87 : 128'h0);
        v = {in_block_high, in_block_low} ^ mask;
        v = (decrypt ? aes_decrypt(v) : aes_encrypt(v)) ^ mask;
        expected_blocks.push_back(v);
      end
      if (out_valid && !out_stall) begin
        got = {out_result_high, out_result_low};
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result %h_%h", $time, got.high, got.low);
          mismatch_count++;
        end else begin
          want = expected_blocks.pop_front();
          if (got.high !== want.high) begin
            $display("%0t: result_high expected %h got %h", $time, want.high, got.high);
            mismatch_count++;
          end
          if (got.low !== want.low) begin
            $display("%0t: result_low expected %h got %h", $time, want.low, got.low);
            mismatch_count++;
          end
        end
      end
    end
    outstanding <= expected_blocks.size();
  end

endmodule

/* dv/tb_top.sv */
// Top of the XEX AES-128 layer testbench: clock, reset, config writes, block stimulus
// and output stalls; verdict from xex_checker. Uses xex_pkg and the unit under test.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import xex_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd5;
  localparam logic [63:0] ONES = '1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 16;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [HALF_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [HALF_W-1:0]    in_block_high;
  logic [HALF_W-1:0]    in_block_low;
  logic                 in_message_start;
  logic                 out_valid;
  logic                 out_stall;
  logic [HALF_W-1:0]    out_result_high;
  logic [HALF_W-1:0]    out_result_low;
  int                   mismatch_count;
  int                   outstanding;
  int                   hold_requests;
  int                   cycles;

  xex_block_cipher_layer_unit uut (.*);

  xex_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls at a redrawn density; each new hold request forces an unbroken stall.
  initial begin
    int served, pct, hold_left;
    served = 0;
    pct = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (cycles % 64 == 0) pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 85);
      if (hold_left == 0 && served != hold_requests) begin
        served = hold_requests;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one block and hold it until the transfer.
  task automatic offer_block(input logic [63:0] hi, input logic [63:0] lo, input logic ms);
    in_valid <= 1'b1;
    in_block_high <= hi;
    in_block_low <= lo;
    in_message_start <= ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Wait until every expected result has arrived and the core is quiet.
  task automatic drain();
    idle_input(1);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    write_reg(CFG_KEY_HIGH, rand64());
    write_reg(CFG_KEY_LOW, rand64());
    write_reg(CFG_BASE_HIGH, ($urandom_range(0, 1) ? rand64() : {1'b1, 63'($urandom)}));
    write_reg(CFG_BASE_LOW, rand64());
    write_reg(CFG_MODE, {$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNMAPPED + 3'($urandom_range(0, 2)), rand64());
  endtask

  // Mostly messages of random length; bursts with random gaps in between, except in hold phases.
  task automatic random_phase(input int count, input bit hold_off);
    int left, msg_left, burst;
    left = count;
    msg_left = 0;
    if (hold_off) hold_requests++;
    while (left > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < burst && left > 0; i++) begin
        if (msg_left == 0) msg_left = $urandom_range(1, 12);
        offer_block(rand64(), rand64(), (msg_left == 1) || ($urandom_range(0, 40) == 0));
        msg_left--;
        left--;
      end
      if (!hold_off) idle_input($urandom_range(0, 12));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_block_high = '0;
    in_block_low = '0;
    in_message_start = 1'b0;
    hold_requests = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // No message start yet: the mask keeps doubling from zero.
    offer_block('0, '0, 1'b0);
    offer_block(ONES, ONES, 1'b0);
    drain();
    // Mask with its top bit set exercises the reduction on doubling.
    write_reg(CFG_KEY_HIGH, ONES);
    write_reg(CFG_KEY_LOW, ONES);
    write_reg(CFG_BASE_HIGH, 64'h8000_0000_0000_0000);
    write_reg(CFG_BASE_LOW, '0);
    write_reg(CFG_MODE, '0);
    offer_block('0, '0, 1'b1);
    offer_block(ONES, ONES, 1'b0);
    offer_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
    offer_block(ONES, '0, 1'b1);
    drain();
    // Upper mode bits are dropped; a base mask write waits for the next start.
    write_reg(CFG_MODE, 64'hffff_ffff_ffff_fffe);
    write_reg(CFG_BASE_HIGH, ONES);
    write_reg(CFG_BASE_LOW, ONES);
    offer_block('0, ONES, 1'b0);
    offer_block(ONES, ONES, 1'b1);
    drain();
    write_reg(CFG_MODE, ONES);
    write_reg(CFG_KEY_HIGH, '0);
    write_reg(CFG_KEY_LOW, '0);
    write_reg(CFG_UNMAPPED, ONES);
    write_reg(CFG_UNMAPPED + 3'd2, ONES);
    offer_block('0, '0, 1'b1);
    offer_block(ONES, ONES, 1'b0);
    offer_block(64'h8000_0000_0000_0001, 64'h1, 1'b1);
    offer_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
    drain();
    write_reg(CFG_BASE_HIGH, '0);
    write_reg(CFG_BASE_LOW, '0);
    write_reg(CFG_MODE, '0);
    offer_block(ONES, ONES, 1'b1);
    offer_block('0, '0, 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      random_phase(165, ph == 2 || ph == 5);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
